/* rtl/core/nrn_pkg.sv */
// Package for the Roman numeral encoder: state type, controller/datapath
// command and status structs, letter codes and the symbol tables.
// No dependencies.
package nrn_pkg;

    localparam int unsigned NUM_W    = 12;
    localparam int unsigned LETTER_W = 7;
    localparam int unsigned NUM_SYMS = 13;
    localparam int unsigned SYM_W    = 4;

    typedef logic [NUM_W-1:0]    t_num;
    typedef logic [LETTER_W-1:0] t_letter;
    typedef logic [SYM_W-1:0]    t_sym;

    localparam t_letter LET_NONE = 7'h00;
    localparam t_letter LET_I    = 7'h49;
    localparam t_letter LET_V    = 7'h56;
    localparam t_letter LET_X    = 7'h58;
    localparam t_letter LET_L    = 7'h4C;
    localparam t_letter LET_C    = 7'h43;
    localparam t_letter LET_D    = 7'h44;
    localparam t_letter LET_M    = 7'h4D;

    typedef enum logic [0:0] {
        S_IDLE,
        S_RUN
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
    } t_cmd;

    typedef struct packed {
        logic work_left;
        logic out_free;
        logic step_last;
        logic num_nonzero;
    } t_sts;

    function automatic t_num sym_value(input t_sym k);
        t_num v;
        unique case (k)
            4'd0:    v = 12'd1000;
            4'd1:    v = 12'd900;
            4'd2:    v = 12'd500;
            4'd3:    v = 12'd400;
            4'd4:    v = 12'd100;
            4'd5:    v = 12'd90;
            4'd6:    v = 12'd50;
            4'd7:    v = 12'd40;
            4'd8:    v = 12'd10;
            4'd9:    v = 12'd9;
            4'd10:   v = 12'd5;
            4'd11:   v = 12'd4;
            default: v = 12'd1;
        endcase
        return v;
    endfunction

    function automatic t_letter sym_first(input t_sym k);
        t_letter c;
        unique case (k)
            4'd0:    c = LET_M;
            4'd1:    c = LET_C;
            4'd2:    c = LET_D;
            4'd3:    c = LET_C;
            4'd4:    c = LET_C;
            4'd5:    c = LET_X;
            4'd6:    c = LET_L;
            4'd7:    c = LET_X;
            4'd8:    c = LET_X;
            4'd9:    c = LET_I;
            4'd10:   c = LET_V;
            default: c = LET_I;
        endcase
        return c;
    endfunction

    // Second letter of a subtractive pair, LET_NONE for plain symbols.
    function automatic t_letter sym_second(input t_sym k);
        t_letter c;
        unique case (k)
            4'd1:    c = LET_M;
            4'd3:    c = LET_D;
            4'd5:    c = LET_C;
            4'd7:    c = LET_L;
            4'd9:    c = LET_X;
            4'd11:   c = LET_V;
            default: c = LET_NONE;
        endcase
        return c;
    endfunction

endpackage

/* rtl/core/nrn_if.sv */
// Handshake interfaces for the Roman numeral encoder: number input channel
// and letter output channel. Depends on nrn_pkg.
interface nrn_num_if;
    logic          valid;
    logic          ready;
    nrn_pkg::t_num number;

    modport source (output valid, output number, input ready);
    modport sink   (input valid, input number, output ready);
endinterface

interface nrn_let_if;
    logic             valid;
    logic             ready;
    nrn_pkg::t_letter letter;
    logic             last;

    modport source (output valid, output letter, output last, input ready);
    modport sink   (input valid, input letter, input last, output ready);
endinterface

/* rtl/core/number_to_roman_numeral_unit.sv */
// Top level of the Roman numeral encoder: joins controller and datapath.
// Depends on nrn_pkg, nrn_if, nrn_ctrl and nrn_datapath.
//
// Usage: a number (0..4095) is offered on i_num; the Roman numeral comes out
// on o_let as a run of ASCII letters, one letter per transfer, with last set
// on the final letter. A zero is taken and yields no transfers at all.
// The input transfer loads the remainder register; the controller then
// steps the first letter into the output register once that is free.
// Throughput: one letter per cycle from the single greedy search/subtract
// step while the receiver keeps up; at most 15 letters (3888).
// The next number is taken as soon as the last letter is in the output
// register, while that letter still waits to be transferred.
// Reset (synchronous, active low) empties the output register and returns
// the controller to idle. When the receiver stalls, the output register
// holds its letter and the datapath waits without losing its place.
module number_to_roman_numeral_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    nrn_num_if.sink           i_num,
    nrn_let_if.source         o_let
);

    nrn_pkg::t_cmd   cmd;
    nrn_pkg::t_sts   sts;
    nrn_pkg::t_state state;

    nrn_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_num.valid),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_ready (i_num.ready),
        .o_state    (state)
    );

    nrn_datapath u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_number (i_num.number),
        .o_sts    (sts),
        .o_valid  (o_let.valid),
        .i_ready  (o_let.ready),
        .o_letter (o_let.letter),
        .o_last   (o_let.last)
    );

    // Idle means the datapath has nothing left to emit.
    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (state == nrn_pkg::S_IDLE) |-> !sts.work_left)
        else $error("idle with letters still to emit");

    // A nonzero number always starts a run.
    a_start_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_num.valid && i_num.ready && (i_num.number != '0))
            |=> (state == nrn_pkg::S_RUN))
        else $error("nonzero number did not start a run");

    // Emitting the last letter of a run returns to idle.
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.step && sts.step_last) |=> (state == nrn_pkg::S_IDLE && o_let.last))
        else $error("last letter did not end the run");

endmodule

/* rtl/core/nrn_datapath.sv */
// Datapath of the Roman numeral encoder: remainder register, greedy symbol
// search, pending second letter and output register. Depends on nrn_pkg.
module nrn_datapath (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  nrn_pkg::t_cmd    i_cmd,
    input  nrn_pkg::t_num    i_number,
    output nrn_pkg::t_sts    o_sts,
    output logic             o_valid,
    input  logic             i_ready,
    output nrn_pkg::t_letter o_letter,
    output logic             o_last
);

    nrn_pkg::t_num    r_rem,    n_rem;
    logic             r_pend,   n_pend;
    nrn_pkg::t_letter r_pend_letter, n_pend_letter;
    logic             r_out_valid;
    nrn_pkg::t_letter r_letter;
    logic             r_last;

    nrn_pkg::t_sym    sel;
    nrn_pkg::t_letter step_letter;
    logic             step_last;

    // Largest symbol value that still fits in the remainder.
    always_comb begin
        sel = nrn_pkg::t_sym'(nrn_pkg::NUM_SYMS - 1);
        for (int k = nrn_pkg::NUM_SYMS - 1; k >= 0; k--) begin
            if (r_rem >= nrn_pkg::sym_value(nrn_pkg::t_sym'(k))) begin
                sel = nrn_pkg::t_sym'(k);
            end
        end
    end

    always_comb begin
        n_rem         = r_rem;
        n_pend        = r_pend;
        n_pend_letter = r_pend_letter;
        if (r_pend) begin
            step_letter = r_pend_letter;
            step_last   = (r_rem == '0);
            n_pend      = 1'b0;
        end else begin
            step_letter   = nrn_pkg::sym_first(sel);
            n_rem         = r_rem - nrn_pkg::sym_value(sel);
            n_pend_letter = nrn_pkg::sym_second(sel);
            n_pend        = (n_pend_letter != nrn_pkg::LET_NONE);
            step_last     = !n_pend && (n_rem == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem       <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_rem  <= i_number;
                r_pend <= 1'b0;
            end else if (i_cmd.step) begin
                r_rem  <= n_rem;
                r_pend <= n_pend;
            end
            if (i_cmd.step) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            r_pend_letter <= n_pend_letter;
            r_letter      <= step_letter;
            r_last        <= step_last;
        end
    end

    assign o_sts.work_left   = r_pend || (r_rem != '0);
    assign o_sts.out_free    = !r_out_valid || i_ready;
    assign o_sts.step_last   = step_last;
    assign o_sts.num_nonzero = (i_number != '0);

    assign o_valid  = r_out_valid;
    assign o_letter = r_letter;
    assign o_last   = r_last;

endmodule

/* rtl/core/nrn_ctrl.sv */
// Controller of the Roman numeral encoder: two-state machine that loads a
// number and steps the datapath one letter at a time. Depends on nrn_pkg.
module nrn_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  nrn_pkg::t_sts   i_sts,
    output nrn_pkg::t_cmd   o_cmd,
    output logic            o_in_ready,
    output nrn_pkg::t_state o_state
);

    nrn_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= nrn_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            nrn_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
                // A zero yields no letters, so it never leaves idle.
                if (i_in_valid && i_sts.num_nonzero) begin
                    n_state = nrn_pkg::S_RUN;
                end
            end
            nrn_pkg::S_RUN: begin
                o_cmd.step = i_sts.out_free;
                if (i_sts.out_free && i_sts.step_last) begin
                    n_state = nrn_pkg::S_IDLE;
                end
            end
            default: n_state = nrn_pkg::S_IDLE;
        endcase
    end

    assign o_state = r_state;

endmodule

/* bench/tb.sv */
// Self-checking testbench for number_to_roman_numeral_unit: a directed table and random numbers
// go in over the number channel, and each letter transfer is checked against a typed numeral or a local encoder.
// Depends on nrn_pkg, nrn_if and the number_to_roman_numeral_unit RTL.
module tb;

    typedef struct {
        nrn_pkg::t_letter letter;
        logic             last;
    } t_roman_letter;

    typedef struct {
        nrn_pkg::t_num number;
        bit            typed;
        string         roman;
    } t_stim_row;

    localparam int unsigned RANDOM_PER_PHASE = 61;
    localparam int unsigned NUM_PHASES       = 5;
    localparam int unsigned HOLD_CYCLES      = 400;

    logic i_clk;
    logic i_rst_n;

    nrn_num_if num_if ();
    nrn_let_if let_if ();

    number_to_roman_numeral_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_num   (num_if),
        .o_let   (let_if)
    );

    t_roman_letter pending_letters[$];
    int unsigned   mismatch_count = 0;
    int unsigned   send_idle      = 0;
    int unsigned   recv_stall     = 0;
    bit            hold_req       = 1'b0;
    logic          hold_on;

    // Rows with a typed numeral are checked against that text; the rest go to the encoder.
    t_stim_row directed_rows [24] = '{
        '{12'd0,    1'b1, ""},
        '{12'd1,    1'b1, "I"},
        '{12'd4,    1'b1, "IV"},
        '{12'd5,    1'b1, "V"},
        '{12'd9,    1'b1, "IX"},
        '{12'd10,   1'b1, "X"},
        '{12'd40,   1'b1, "XL"},
        '{12'd50,   1'b1, "L"},
        '{12'd90,   1'b1, "XC"},
        '{12'd100,  1'b1, "C"},
        '{12'd400,  1'b1, "CD"},
        '{12'd500,  1'b1, "D"},
        '{12'd900,  1'b1, "CM"},
        '{12'd1000, 1'b1, "M"},
        '{12'd3888, 1'b1, "MMMDCCCLXXXVIII"},
        '{12'd4000, 1'b1, "MMMM"},
        '{12'd4095, 1'b1, "MMMMXCV"},
        '{12'd3999, 1'b1, "MMMCMXCIX"},
        '{12'd444,  1'b1, "CDXLIV"},
        '{12'd0,    1'b1, ""},
        '{12'd2730, 1'b0, ""},
        '{12'd1365, 1'b0, ""},
        '{12'd2048, 1'b0, ""},
        '{12'd1234, 1'b0, ""}
    };

    function automatic void predict_roman(input nrn_pkg::t_num number);
        int unsigned      weight [13] = '{1000, 900, 500, 400, 100, 90, 50, 40, 10, 9, 5, 4, 1};
        nrn_pkg::t_letter head   [13] = '{nrn_pkg::LET_M, nrn_pkg::LET_C, nrn_pkg::LET_D,
                                          nrn_pkg::LET_C, nrn_pkg::LET_C, nrn_pkg::LET_X,
                                          nrn_pkg::LET_L, nrn_pkg::LET_X, nrn_pkg::LET_X,
                                          nrn_pkg::LET_I, nrn_pkg::LET_V, nrn_pkg::LET_I,
                                          nrn_pkg::LET_I};
        nrn_pkg::t_letter tail   [13] = '{nrn_pkg::LET_NONE, nrn_pkg::LET_M, nrn_pkg::LET_NONE,
                                          nrn_pkg::LET_D, nrn_pkg::LET_NONE, nrn_pkg::LET_C,
                                          nrn_pkg::LET_NONE, nrn_pkg::LET_L, nrn_pkg::LET_NONE,
                                          nrn_pkg::LET_X, nrn_pkg::LET_NONE, nrn_pkg::LET_V,
                                          nrn_pkg::LET_NONE};
        int unsigned      rest;
        t_roman_letter    run[$];
        rest = 32'(number);
        for (int k = 0; k < 13; k++) begin
            while (rest >= weight[k]) begin
                rest -= weight[k];
                run.push_back('{head[k], 1'b0});
                if (tail[k] != nrn_pkg::LET_NONE) begin
                    run.push_back('{tail[k], 1'b0});
                end
            end
        end
        if (run.size() != 0) begin
            run[run.size()-1].last = 1'b1;
        end
        foreach (run[i]) begin
            pending_letters.push_back(run[i]);
        end
    endfunction

    function automatic void push_typed_roman(input string roman);
        for (int i = 0; i < roman.len(); i++) begin
            pending_letters.push_back('{nrn_pkg::t_letter'(roman[i]),
                                        logic'(i == roman.len() - 1)});
        end
    endfunction

    // Biased toward zero, small values and long numerals built digit by digit.
    function automatic nrn_pkg::t_num pick_number();
        int unsigned pick;
        int unsigned thousands;
        pick = $urandom_range(99);
        if (pick < 8) begin
            return nrn_pkg::t_num'(0);
        end else if (pick < 20) begin
            return nrn_pkg::t_num'($urandom_range(1, 20));
        end else if (pick < 45) begin
            thousands = $urandom_range(4);
            if (thousands == 4) begin
                return nrn_pkg::t_num'(4000 + $urandom_range(95));
            end
            return nrn_pkg::t_num'(thousands * 1000 + $urandom_range(9) * 100
                                   + $urandom_range(9) * 10 + $urandom_range(9));
        end
        return nrn_pkg::t_num'($urandom_range(4095));
    endfunction

    // Offers one number, keeping valid high across back-to-back transfers.
    task automatic offer_number(input nrn_pkg::t_num number, input bit typed,
                                input string roman);
        while ($urandom_range(99) < send_idle) begin
            num_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        num_if.valid  <= 1'b1;
        num_if.number <= number;
        do @(posedge i_clk); while (num_if.ready !== 1'b1);
        if (typed) begin
            push_typed_roman(roman);
        end else begin
            predict_roman(number);
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever begin
            #5 i_clk = 1'b1;
            #5 i_clk = 1'b0;
        end
    end

    initial begin
        #3000000;
        $display("number_to_roman_numeral_unit test failed");
        $finish;
    end

    // Long receiver hold-off so the block fills up and stalls its input.
    initial begin
        hold_on = 1'b0;
        wait (hold_req);
        @(posedge i_clk);
        hold_on <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_on <= 1'b0;
    end

    initial begin
        t_roman_letter exp_letter;
        let_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && let_if.valid === 1'b1 && let_if.ready === 1'b1) begin
                if (pending_letters.size() == 0) begin
                    $error("letter: expected none, actual %h (last %b)",
                           let_if.letter, let_if.last);
                    mismatch_count++;
                end else begin
                    exp_letter = pending_letters.pop_front();
                    if (let_if.letter !== exp_letter.letter) begin
                        $error("letter: expected %h, actual %h",
                               exp_letter.letter, let_if.letter);
                        mismatch_count++;
                    end
                    if (let_if.last !== exp_letter.last) begin
                        $error("last: expected %b, actual %b", exp_letter.last, let_if.last);
                        mismatch_count++;
                    end
                end
            end
            let_if.ready <= !hold_on && ($urandom_range(99) >= recv_stall);
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        num_if.valid  = 1'b0;
        num_if.number = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            offer_number(directed_rows[i].number, directed_rows[i].typed,
                         directed_rows[i].roman);
        end

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0: begin send_idle = 0;  recv_stall <= 0;  end
                1: begin send_idle = 86; recv_stall <= 0;  end
                2: begin send_idle = 0;  recv_stall <= 86; end
                3: begin send_idle = 14; recv_stall <= 14; end
                default: begin
                    send_idle  = 0;
                    recv_stall <= 0;
                    hold_req   = 1'b1;
                end
            endcase
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                offer_number(pick_number(), 1'b0, "");
            end
        end

        num_if.valid <= 1'b0;
        recv_stall   <= 0;
        while (pending_letters.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("number_to_roman_numeral_unit test passed");
        end else begin
            $display("number_to_roman_numeral_unit test failed");
        end
        $finish;
    end
endmodule
